// ===== sv/fdi_pkg.sv =====
package fdi_pkg;

    localparam int TBL_DEPTH = 16;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);
    localparam int CFG_W     = 5;
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int Q_W       = FRAC_W + 1;
    localparam int ACC_W     = DATA_W + FRAC_W;

    localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(1) << FRAC_W;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        WHERE_INTERP = 2'd0,
        WHERE_FIRST  = 2'd1,
        WHERE_ABOVE  = 2'd2
    } t_where;

    typedef struct packed {
        logic   load;
        logic   start;
        logic   step;
        logic   span;
        logic   div;
        logic   mul_first;
        logic   mul_second;
        logic   put;
        logic   put_interp;
        t_where code;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic at_first;
        logic at_last;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/fog_density_interpolator_unit.sv =====
// Piecewise linear fog density by camera height. Load requests (kind 0) write one
// (height, density) slot of a 16-entry table and give no result; the table must be
// kept sorted by ascending height, and i_cfg_wdata sets how many leading entries are
// in use (0 counts as 1, anything above 16 as 16). A query request (kind 1) gives one
// density: at or below the first entry it returns the first density, above the last
// entry the last density, otherwise a linear blend with a Q1.16 fraction. A query
// scans the table entry by entry until it finds the result (one registered table
// read per entry visited), and an interpolated query then runs the bit-serial
// divider and the shared 32x17 multiplier. One request is worked on at a time; a
// finished result waits in the output register while the next request is taken.
// Table slots read before they are written return undefined values.
module fog_density_interpolator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fdi_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_kind,
    input  logic [3:0]                         i_entry_index,
    input  logic signed [fdi_pkg::DATA_W-1:0]  i_entry_height,
    input  logic [fdi_pkg::DATA_W-1:0]         i_entry_density,
    input  logic signed [fdi_pkg::DATA_W-1:0]  i_query_height,
    input  logic                               i_has_position,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [fdi_pkg::DATA_W-1:0]         o_fog_density,
    output logic [1:0]                         o_where_found
);

    fdi_pkg::t_cmd  w_cmd;
    fdi_pkg::t_stat w_stat;

    // Sequence the scan, divide and blend steps.
    fdi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Hold the table, the entry count, the divider, the multiplier and the result.
    fdi_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_entry_index   (i_entry_index),
        .i_entry_height  (i_entry_height),
        .i_entry_density (i_entry_density),
        .i_query_height  (i_query_height),
        .i_has_position  (i_has_position),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_fog_density   (o_fog_density),
        .o_where_found   (o_where_found)
    );

    // A query request keeps the input side closed on the following cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_kind == fdi_pkg::KIND_QUERY) |=> !o_ready)
        else $error("input side open right after a query request");

    // A load request never raises a result on its own.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_kind == fdi_pkg::KIND_LOAD && !o_valid) |=> !o_valid)
        else $error("result raised by a load request");

    // A shown result carries a meaningful position code.
    a_where_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_where_found != 2'd3))
        else $error("result with an unused position code");

endmodule

// ===== sv/fdi_ctrl.sv =====
module fdi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_kind,
    output logic          o_ready,
    input  fdi_pkg::t_stat i_stat,
    output fdi_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_WRITE
    } t_state;

    t_state          r_state, n_state;
    fdi_pkg::t_where r_code, n_code;
    logic            r_interp, n_interp;
    logic            w_accept;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state  = r_state;
        n_code   = r_code;
        n_interp = r_interp;
        o_cmd    = '0;
        o_cmd.code       = r_code;
        o_cmd.put_interp = r_interp;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_kind == fdi_pkg::KIND_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_stat.hit && i_stat.at_first) begin
                    n_code   = fdi_pkg::WHERE_FIRST;
                    n_interp = 1'b0;
                    n_state  = ST_WRITE;
                end else if (i_stat.hit) begin
                    o_cmd.span = 1'b1;
                    n_code     = fdi_pkg::WHERE_INTERP;
                    n_interp   = 1'b1;
                    n_state    = ST_DIV;
                end else if (i_stat.at_last) begin
                    n_code   = fdi_pkg::WHERE_ABOVE;
                    n_interp = 1'b0;
                    n_state  = ST_WRITE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul_first = 1'b1;
                n_state         = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul_second = 1'b1;
                n_state          = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_code   <= fdi_pkg::WHERE_INTERP;
            r_interp <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_code   <= n_code;
            r_interp <= n_interp;
        end
    end

endmodule

// ===== sv/fdi_dp.sv =====
module fdi_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fdi_pkg::t_cmd                      i_cmd,
    output fdi_pkg::t_stat                     o_stat,
    input  logic                               i_cfg_we,
    input  logic [fdi_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic [3:0]                         i_entry_index,
    input  logic signed [fdi_pkg::DATA_W-1:0]  i_entry_height,
    input  logic [fdi_pkg::DATA_W-1:0]         i_entry_density,
    input  logic signed [fdi_pkg::DATA_W-1:0]  i_query_height,
    input  logic                               i_has_position,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [fdi_pkg::DATA_W-1:0]         o_fog_density,
    output logic [1:0]                         o_where_found
);

    localparam int DW = fdi_pkg::DATA_W;
    localparam int AW = fdi_pkg::ADDR_W;

    logic signed [DW-1:0] r_tbl_h [fdi_pkg::TBL_DEPTH];
    logic [DW-1:0]        r_tbl_d [fdi_pkg::TBL_DEPTH];

    logic [fdi_pkg::CFG_W-1:0] r_cfg;
    logic [AW-1:0]             w_last_idx;

    logic signed [DW-1:0] r_h, r_rd_h, r_prev_h;
    logic [DW-1:0]        r_rd_d, r_prev_d, r_da, r_db, r_den;
    logic [AW-1:0]        r_k, n_k;

    logic [DW:0]                r_rem;
    logic [fdi_pkg::Q_W-1:0]    r_q;
    logic [4:0]                 r_dcnt;
    logic [fdi_pkg::ACC_W-1:0]  r_acc;

    logic                        r_out_v;
    logic [DW-1:0]               r_out_d;
    logic [1:0]                  r_out_w;

    logic signed [DW:0]          w_num, w_den;
    logic [DW:0]                 w_sub;
    logic                        w_ge;
    logic [DW-1:0]               w_rem_n;
    logic [DW-1:0]               w_mul_a;
    logic [fdi_pkg::Q_W-1:0]     w_mul_b;
    logic [DW+fdi_pkg::Q_W-1:0]  w_prod;

    // Entry count, saturated to the table depth, with zero taken as one.
    always_comb begin
        if (r_cfg == '0) begin
            w_last_idx = '0;
        end else if (r_cfg > fdi_pkg::CFG_W'(fdi_pkg::TBL_DEPTH)) begin
            w_last_idx = AW'(fdi_pkg::TBL_DEPTH - 1);
        end else begin
            w_last_idx = AW'(r_cfg - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= fdi_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // Table memory: one write port, one registered read port.
    always_comb begin
        n_k = r_k;
        if (i_cmd.start) begin
            n_k = '0;
        end else if (i_cmd.step) begin
            n_k = r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (32'(i_entry_index) < fdi_pkg::TBL_DEPTH)) begin
            r_tbl_h[AW'(i_entry_index)] <= i_entry_height;
            r_tbl_d[AW'(i_entry_index)] <= i_entry_density;
        end
        r_rd_h <= r_tbl_h[n_k];
        r_rd_d <= r_tbl_d[n_k];
    end

    assign w_num   = {r_h[DW-1], r_h} - {r_prev_h[DW-1], r_prev_h};
    assign w_den   = {r_rd_h[DW-1], r_rd_h} - {r_prev_h[DW-1], r_prev_h};
    assign w_ge    = (r_rem >= {1'b0, r_den});
    assign w_sub   = r_rem - {1'b0, r_den};
    assign w_rem_n = w_ge ? w_sub[DW-1:0] : r_rem[DW-1:0];

    assign w_mul_a = i_cmd.mul_second ? r_db : r_da;
    assign w_mul_b = i_cmd.mul_second ? r_q : (fdi_pkg::ONE_Q16 - r_q);
    assign w_prod  = {{fdi_pkg::Q_W{1'b0}}, w_mul_a} * {{DW{1'b0}}, w_mul_b};

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (i_cmd.start) begin
            r_h <= i_has_position ? i_query_height : '0;
        end
        if (i_cmd.step) begin
            r_prev_h <= r_rd_h;
            r_prev_d <= r_rd_d;
        end
        if (i_cmd.span) begin
            r_rem  <= {1'b0, w_num[DW-1:0]};
            r_den  <= w_den[DW-1:0];
            r_da   <= r_prev_d;
            r_db   <= r_rd_d;
            r_q    <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div) begin
            r_rem  <= {w_rem_n, 1'b0};
            r_q    <= {r_q[fdi_pkg::Q_W-2:0], w_ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.mul_first) begin
            r_acc <= fdi_pkg::ACC_W'(w_prod);
        end else if (i_cmd.mul_second) begin
            r_acc <= r_acc + fdi_pkg::ACC_W'(w_prod);
        end
        if (i_cmd.put) begin
            r_out_d <= i_cmd.put_interp ? r_acc[fdi_pkg::ACC_W-1:fdi_pkg::FRAC_W] : r_rd_d;
            r_out_w <= i_cmd.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.put) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_stat.hit      = (r_rd_h >= r_h);
    assign o_stat.at_first = (r_k == '0);
    assign o_stat.at_last  = (r_k == w_last_idx);
    assign o_stat.div_last = (r_dcnt == 5'(fdi_pkg::Q_W - 1));
    assign o_stat.out_free = !r_out_v || i_ready;

    assign o_valid       = r_out_v;
    assign o_fog_density = r_out_d;
    assign o_where_found = r_out_w;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import fdi_pkg::*;

    // Timing of the run. Hold the settle pause above the worst query latency
    // (2 + 16 table reads + 17 divide steps + 2 multiply steps).
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int ITEMS_PER_SET  = 40;

    localparam logic signed [DATA_W-1:0] HGT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] HGT_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                      kind;
        logic [ADDR_W-1:0]         slot;
        logic signed [DATA_W-1:0]  entry_height;
        logic [DATA_W-1:0]         entry_density;
        logic signed [DATA_W-1:0]  query_height;
        logic                      has_position;
    } t_fog_request;

    typedef struct packed {
        logic [DATA_W-1:0] density;
        t_where            where;
    } t_fog_result;

    // Ports of the block; every input starts at a known value.
    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_cfg_we        = 1'b0;
    logic [CFG_W-1:0]          i_cfg_wdata     = '0;
    logic                      i_valid         = 1'b0;
    logic                      o_ready;
    logic                      i_kind          = KIND_LOAD;
    logic [ADDR_W-1:0]         i_entry_index   = '0;
    logic signed [DATA_W-1:0]  i_entry_height  = '0;
    logic [DATA_W-1:0]         i_entry_density = '0;
    logic signed [DATA_W-1:0]  i_query_height  = '0;
    logic                      i_has_position  = 1'b0;
    logic                      o_valid;
    logic                      i_ready         = 1'b0;
    logic [DATA_W-1:0]         o_fog_density;
    logic [1:0]                o_where_found;

    // Shadow copy of the block's table, updated as each load request is
    // accepted, and of its entry count, updated as it is written.
    logic signed [DATA_W-1:0]  tbl_height  [TBL_DEPTH];
    logic [DATA_W-1:0]         tbl_density [TBL_DEPTH];
    logic [CFG_W-1:0]          entry_count = 5'd1;

    // Densities still owed by the block, oldest first.
    t_fog_result expected_fog [$];

    int mismatch_count    = 0;
    int sender_idle_pct   = 24;
    int receiver_idle_pct = 65;
    int holdoff_request   = 0;
    int holdoff_left      = 0;

    fog_density_interpolator_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_entry_index   (i_entry_index),
        .i_entry_height  (i_entry_height),
        .i_entry_density (i_entry_density),
        .i_query_height  (i_query_height),
        .i_has_position  (i_has_position),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_fog_density   (o_fog_density),
        .o_where_found   (o_where_found)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ERROR %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Number of leading entries the scan may visit: zero counts as one and
    // anything above the table depth saturates.
    function automatic int active_entries();
        if (entry_count == 0)
            return 1;
        if (entry_count > TBL_DEPTH)
            return TBL_DEPTH;
        return int'(entry_count);
    endfunction

    // Work out the density for one query against the shadow table.
    function automatic t_fog_result predict_fog(logic signed [DATA_W-1:0] qh, logic has_pos);
        t_fog_result res;
        longint h, ha, hb, frac, da, db, dens;
        int n, k;
        h = has_pos ? longint'(qh) : 64'sd0;
        n = active_entries();
        k = 0;
        // Advance to the first entry at or above the query height.
        while (k < n && longint'(tbl_height[k]) < h)
            k++;
        if (k == n) begin
            res.density = tbl_density[n-1];
            res.where   = WHERE_ABOVE;
        end else if (k == 0) begin
            res.density = tbl_density[0];
            res.where   = WHERE_FIRST;
        end else begin
            // The scan leaves ha < h <= hb, so the span is never zero.
            ha   = longint'(tbl_height[k-1]);
            hb   = longint'(tbl_height[k]);
            frac = ((h - ha) * 65536) / (hb - ha);
            if (frac > 65536)
                frac = 65536;
            da   = longint'({32'b0, tbl_density[k-1]});
            db   = longint'({32'b0, tbl_density[k]});
            dens = (da * (65536 - frac) + db * frac) >>> 16;
            res.density = dens[DATA_W-1:0];
            res.where   = WHERE_INTERP;
        end
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] to_height(longint v);
        if (v > longint'(HGT_MAX))
            return HGT_MAX;
        if (v < longint'(HGT_MIN))
            return HGT_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic longint rand_between(longint lo, longint hi);
        longint unsigned span;
        span = longint'(hi - lo) + 1;
        return lo + longint'({$urandom, $urandom} % span);
    endfunction

    function automatic logic [DATA_W-1:0] pick_density();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Load request; fill the ignored query fields with noise.
    function automatic t_fog_request make_load(int slot, logic signed [DATA_W-1:0] h,
                                               logic [DATA_W-1:0] d);
        t_fog_request r;
        r.kind          = KIND_LOAD;
        r.slot          = slot[ADDR_W-1:0];
        r.entry_height  = h;
        r.entry_density = d;
        r.query_height  = $urandom;
        r.has_position  = 1'($urandom_range(1));
        return r;
    endfunction

    // Query request; fill the ignored load fields with noise.
    function automatic t_fog_request make_query(logic signed [DATA_W-1:0] h, logic has_pos);
        t_fog_request r;
        r.kind          = KIND_QUERY;
        r.slot          = ADDR_W'($urandom);
        r.entry_height  = $urandom;
        r.entry_density = $urandom;
        r.query_height  = h;
        r.has_position  = has_pos;
        return r;
    endfunction

    // Aim most queries at the interesting spots of the live table: on an
    // entry, between neighbours, just outside either end.
    function automatic t_fog_request random_query();
        int n, k;
        longint ha, hb;
        n = active_entries();
        k = $urandom_range(n - 1);
        case ($urandom_range(5))
            0: return make_query(tbl_height[k], 1'b1);
            1: begin
                if (n < 2)
                    return make_query(tbl_height[0], 1'b1);
                k  = $urandom_range(n - 1, 1);
                ha = longint'(tbl_height[k-1]);
                hb = longint'(tbl_height[k]);
                if (ha > hb)
                    return make_query(to_height(rand_between(hb, ha)), 1'b1);
                return make_query(to_height(rand_between(ha, hb)), 1'b1);
            end
            2: return make_query(to_height(longint'(tbl_height[0]) -
                                           $urandom_range(1000)), 1'b1);
            3: return make_query(to_height(longint'(tbl_height[n-1]) +
                                           $urandom_range(1000)), 1'b1);
            4: return make_query($urandom, 1'($urandom_range(1)));
            default: return make_query($urandom, 1'b0);
        endcase
    endfunction

    // Mostly issue a query; when rewriting a slot, mostly keep the table sorted
    // and now and then drop an arbitrary height in to break the order.
    function automatic t_fog_request random_request();
        int slot;
        longint lo, hi;
        if ($urandom_range(99) >= 20)
            return random_query();
        slot = $urandom_range(TBL_DEPTH - 1);
        lo = (slot == 0) ? longint'(HGT_MIN) : longint'(tbl_height[slot-1]);
        hi = (slot == TBL_DEPTH - 1) ? longint'(HGT_MAX) : longint'(tbl_height[slot+1]);
        if ($urandom_range(2) != 0 && lo <= hi)
            return make_load(slot, to_height(rand_between(lo, hi)), pick_density());
        return make_load(slot, $urandom, pick_density());
    endfunction

    // Offer one request and hold it until accepted. Valid is left high on
    // return so that a back-to-back request follows with no gap in valid.
    task automatic send_request(t_fog_request r);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= r.kind;
        i_entry_index   <= r.slot;
        i_entry_height  <= r.entry_height;
        i_entry_density <= r.entry_density;
        i_query_height  <= r.query_height;
        i_has_position  <= r.has_position;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        // Accepted at this edge: update the shadow table or queue the result.
        if (r.kind == KIND_LOAD) begin
            tbl_height[r.slot]  = r.entry_height;
            tbl_density[r.slot] = r.entry_density;
        end else begin
            expected_fog.push_back(predict_fog(r.query_height, r.has_position));
        end
    endtask

    // Write the entry count only once the block has gone quiet: drain every
    // owed result, then wait out a trailing load.
    task automatic write_entry_count(logic [CFG_W-1:0] value);
        i_valid <= 1'b0;
        while (expected_fog.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        entry_count = value;
        i_cfg_we    <= 1'b0;
    endtask

    // Load a fresh ascending table over all slots, with steps from tiny to
    // very wide and the odd repeated height.
    task automatic fill_sorted_table();
        longint h;
        h = rand_between(longint'(HGT_MIN), 64'sd1073741823);
        for (int s = 0; s < TBL_DEPTH; s++) begin
            send_request(make_load(s, to_height(h), pick_density()));
            case ($urandom_range(3))
                0:       h += $urandom_range(8);
                1:       h += $urandom_range(65536);
                2:       h += $urandom_range(134217728);
                default: h += 0;
            endcase
        end
    endtask

    // Three sorted entries spanning the whole height range: both ends, exact
    // hits, the widest spans, a full fraction and a query with no position.
    task automatic test_directed_interpolation();
        write_entry_count(5'd3);
        send_request(make_load(0, HGT_MIN, 32'hFFFF_FFFF));
        send_request(make_load(1, 32'sd0, 32'h8000_0000));
        send_request(make_load(2, HGT_MAX, 32'h0000_0000));
        send_request(make_query(HGT_MIN, 1'b1));
        send_request(make_query($urandom, 1'b0));
        send_request(make_query(HGT_MAX, 1'b1));
        send_request(make_query(32'sd1, 1'b1));
        send_request(make_query(-32'sd1, 1'b1));
        // Pull the last entry down so that a query can pass above it.
        send_request(make_load(2, 32'sd100, 32'h1234_5678));
        send_request(make_query(HGT_MAX, 1'b1));
        send_request(make_query(32'sd100, 1'b1));
        send_request(make_query(32'sd50, 1'b1));
    endtask

    // An entry count of zero behaves as a single entry.
    task automatic test_zero_entry_count();
        write_entry_count(5'd0);
        send_request(make_query(32'sd5, 1'b1));
        send_request(make_query(HGT_MIN, 1'b1));
    endtask

    // Break the order on purpose: the scan still stops at the first entry
    // at or above the query.
    task automatic test_unsorted_table();
        write_entry_count(5'd3);
        send_request(make_load(1, HGT_MAX, 32'h0000_FFFF));
        send_request(make_load(2, 32'sd10, 32'hDEAD_BEEF));
        send_request(make_query(32'sd20, 1'b1));
        send_request(make_query(32'sd5, 1'b1));
        send_request(make_query(HGT_MAX, 1'b1));
    endtask

    // Random traffic in three idling regimes, each over three entry counts;
    // between them the full table, saturation above the depth, zero, one,
    // two and a random pick.
    task automatic test_random_traffic();
        int sender_plan   [3] = '{24, 65, 0};
        int receiver_plan [3] = '{65, 24, 0};
        int count_plan    [6] = '{16, 31, 0, 1, 16, 2};
        logic [CFG_W-1:0] setting;
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct   = sender_plan[phase];
            receiver_idle_pct = receiver_plan[phase];
            fill_sorted_table();
            for (int s = 0; s < 3; s++) begin
                setting = (s == 2) ? CFG_W'($urandom_range(31))
                                   : CFG_W'(count_plan[2*phase+s]);
                write_entry_count(setting);
                repeat (ITEMS_PER_SET) send_request(random_request());
            end
        end
    endtask

    // Hold the output off for a long stretch while queries keep coming, so
    // that the block fills and drops ready.
    task automatic test_output_backpressure();
        write_entry_count(5'd16);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        holdoff_request   = HOLDOFF_CYCLES;
        repeat (12) send_request(random_query());
    endtask

    // Result side: check each accepted result against the oldest expected
    // one, then decide ready for the next edge.
    always @(posedge i_clk) begin
        t_fog_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_fog.size() == 0) begin
                report_mismatch("density with no query pending", o_fog_density, '0);
            end else begin
                want = expected_fog.pop_front();
                if (o_fog_density !== want.density)
                    report_mismatch("fog_density", o_fog_density, want.density);
                if (o_where_found !== want.where)
                    report_mismatch("where_found", {30'b0, o_where_found}, {30'b0, want.where});
            end
        end
        // Pick up a hold-off request and count it down here.
        if (holdoff_left == 0 && holdoff_request != 0) begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // End the run if nothing moves on either side for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t ERROR no request or result moved for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_interpolation();
        test_zero_entry_count();
        test_unsorted_table();
        test_random_traffic();
        test_output_backpressure();

        // Drain what is still owed, then watch for stray results.
        i_valid <= 1'b0;
        while (expected_fog.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_fog.size() != 0)
            report_mismatch("densities never returned", expected_fog.size(), '0);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
